@@ src/fitc_pkg.sv @@
// fitc_pkg: shared widths, codes and control/status structs for the
// flat index to coordinates block. No dependencies.
package fitc_pkg;

    localparam int MAX_DIMS_DEF = 6;
    localparam int NUM_EXTENTS  = 6;

    localparam int OPC_W    = 1;
    localparam int POS_W    = 32;
    localparam int EXT_W    = 16;
    localparam int DIM_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int EXT_IDX_W = 3;

    // request opcodes
    localparam logic [OPC_W-1:0] OPC_NEXT = 1'b0;
    localparam logic [OPC_W-1:0] OPC_SEEK = 1'b1;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_FIRST = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_LAST  = 4'd7;

    typedef struct packed {
        logic take_req;
        logic load_seek;
        logic walk_init;
        logic div_start;
        logic div_store;
        logic emit_ack;
        logic emit_exh;
        logic emit_coord;
    } fitc_cmd_t;

    typedef struct packed {
        logic op_seek;
        logic exhausted;
        logic div_busy;
        logic div_done;
        logic div_dim_zero;
        logic emit_last;
        logic out_free;
    } fitc_status_t;

endpackage

@@ src/fitc_ifs.sv @@
// fitc interfaces: request, result and register write channels.
// Depends on fitc_pkg.
interface fitc_req_if;
    import fitc_pkg::*;
    logic               valid;
    logic               ready;
    logic [OPC_W-1:0]   opcode;
    logic [POS_W-1:0]   seek_position;
    modport source (output valid, opcode, seek_position, input ready);
    modport sink   (input valid, opcode, seek_position, output ready);
endinterface

interface fitc_res_if;
    import fitc_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIM_W-1:0]   dimension;
    logic [EXT_W-1:0]   coordinate;
    logic [POS_W-1:0]   position;
    logic               exhausted;
    logic               last;
    modport source (output valid, dimension, coordinate, position, exhausted, last,
                    input ready);
    modport sink   (input valid, dimension, coordinate, position, exhausted, last,
                    output ready);
endinterface

interface fitc_cfg_if;
    import fitc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/flat_index_to_coordinates.sv @@
// flat_index_to_coordinates: row-major coordinate enumerator, top level.
// A seek or exhausted answer is decided in the dispatch state and loaded from the
// acknowledge or exhausted state; a next request divides out its n dimensions in the
// one-bit-per-cycle divider (start, one iteration per quotient bit, store), then sends
// coordinates one per cycle while the result register is free. One request in flight.
// Reset (rst_n, async, low) clears the position counter to 0 and sets every configuration register to 1.
module flat_index_to_coordinates
#(
    parameter int MAX_DIMS = fitc_pkg::MAX_DIMS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    fitc_req_if.sink    req,
    fitc_res_if.source  res,
    fitc_cfg_if.sink    cfg
);
    import fitc_pkg::*;

    fitc_cmd_t      cmd;
    fitc_status_t   status;

    // register writes are always taken; the map is only to be written while idle (a user duty, unchecked by the block)
    assign cfg.ready = 1'b1;

    // Controller: one request at a time. A seek loads the counter and answers
    // with one acknowledge; a next request at or past the total answers with
    // one exhausted result; otherwise dimensions are divided out innermost
    // first into the coordinate store, then sent outermost first.
    fitc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: registers, position counter, divider, coordinate store and a
    // result register that decouples the result side from the sequencer.
    fitc_datapath #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .req_opcode        (req.opcode),
        .req_seek_position (req.seek_position),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .res_ready         (res.ready),
        .res_valid         (res.valid),
        .res_dimension     (res.dimension),
        .res_coordinate    (res.coordinate),
        .res_position      (res.position),
        .res_exhausted     (res.exhausted),
        .res_last          (res.last)
    );

`ifndef SYNTHESIS
    // a result is only loaded when the result register is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ack || cmd.emit_exh || cmd.emit_coord) |-> (!res.valid || res.ready))
        else $error("result register overwritten");

    // no new request while the divider still works on the previous one
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !status.div_busy)
        else $error("request taken with divider busy");

    // an exhausted answer is a single result for dimension 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.exhausted) |-> (res.last && res.dimension == '0))
        else $error("malformed exhausted result");

    // while a multi-result answer is still open, no request is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> !req.ready)
        else $error("request taken mid-answer");
`endif

endmodule

@@ src/fitc_divider.sv @@
// fitc_divider: restoring divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle. Depends on fitc_pkg.
module fitc_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fitc_pkg::POS_W-1:0]  dividend,
    input  logic [fitc_pkg::EXT_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [fitc_pkg::POS_W-1:0]  quotient,
    output logic [fitc_pkg::EXT_W-1:0]  remainder
);
    import fitc_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [POS_W-1:0]   quo_reg, quo_next;
    logic [EXT_W-1:0]   rem_reg, rem_next;
    logic [EXT_W-1:0]   dvs_reg;
    logic [EXT_W:0]     shifted;
    logic               ge;

    assign shifted = {rem_reg, quo_reg[POS_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(POS_W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            quo_next  = {quo_reg[POS_W-2:0], ge};
            rem_next  = ge ? EXT_W'(shifted - {1'b0, dvs_reg}) : shifted[EXT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/fitc_datapath.sv @@
// fitc_datapath: registers, position counter, coordinate store, divider and
// result register. Depends on fitc_pkg and fitc_divider.
module fitc_datapath
#(
    parameter int MAX_DIMS = fitc_pkg::MAX_DIMS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fitc_pkg::fitc_cmd_t             cmd,
    output fitc_pkg::fitc_status_t          status,
    input  logic [fitc_pkg::OPC_W-1:0]      req_opcode,
    input  logic [fitc_pkg::POS_W-1:0]      req_seek_position,
    input  logic                            cfg_valid,
    input  logic [fitc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fitc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            res_ready,
    output logic                            res_valid,
    output logic [fitc_pkg::DIM_W-1:0]      res_dimension,
    output logic [fitc_pkg::EXT_W-1:0]      res_coordinate,
    output logic [fitc_pkg::POS_W-1:0]      res_position,
    output logic                            res_exhausted,
    output logic                            res_last
);
    import fitc_pkg::*;

    localparam int CIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // configuration
    logic [DIM_W-1:0]       dim_count_reg;
    logic [POS_W-1:0]       total_reg;
    logic [EXT_W-1:0]       extent_reg [NUM_EXTENTS];
    logic [CFG_IDX_W-1:0]   ext_off;

    // request and walk state
    logic [OPC_W-1:0]       op_reg;
    logic [POS_W-1:0]       seek_reg;
    logic [POS_W-1:0]       flat_pos_reg;
    logic [POS_W-1:0]       rest_reg;
    logic [DIM_W-1:0]       div_dim_reg;
    logic [DIM_W-1:0]       emit_dim_reg;
    logic [EXT_W-1:0]       coord_mem [MAX_DIMS];

    // result register
    logic                   res_valid_reg;
    logic [DIM_W-1:0]       res_dim_reg;
    logic [EXT_W-1:0]       res_coord_reg;
    logic [POS_W-1:0]       res_pos_reg;
    logic                   res_exh_reg;
    logic                   res_last_reg;

    logic [DIM_W-1:0]       dims_used;
    logic [EXT_W-1:0]       ext_cur;
    logic                   ext_zero;
    logic                   emit_last;
    logic                   out_free;
    logic                   div_busy;
    logic                   div_done;
    logic [POS_W-1:0]       div_quo;
    logic [EXT_W-1:0]       div_rem;

    assign ext_off = cfg_index - CFG_EXTENT_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= DIM_W'(1);
            total_reg     <= POS_W'(1);
            for (int i = 0; i < NUM_EXTENTS; i++)
            begin
                extent_reg[i] <= EXT_W'(1);
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                CFG_DIM_COUNT: dim_count_reg <= cfg_data[DIM_W-1:0];
                CFG_TOTAL:     total_reg     <= cfg_data[POS_W-1:0];
                [CFG_EXTENT_FIRST:CFG_EXTENT_LAST]:
                    extent_reg[ext_off[EXT_IDX_W-1:0]] <= cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one dimension, anything above the limit as the limit
    always_comb
    begin
        if (dim_count_reg == '0)
        begin
            dims_used = DIM_W'(1);
        end
        else if (dim_count_reg > DIM_W'(MAX_DIMS))
        begin
            dims_used = DIM_W'(MAX_DIMS);
        end
        else
        begin
            dims_used = dim_count_reg;
        end
    end

    assign ext_cur   = extent_reg[div_dim_reg];
    assign ext_zero  = (ext_cur == '0);
    assign emit_last = (emit_dim_reg == dims_used - 1'b1);
    assign out_free  = !res_valid_reg || res_ready;

    fitc_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (rest_reg),
        .divisor   (ext_cur),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_pos_reg <= '0;
        end
        else if (cmd.load_seek)
        begin
            flat_pos_reg <= seek_reg;
        end
        else if (cmd.emit_coord && emit_last)
        begin
            flat_pos_reg <= flat_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            op_reg   <= req_opcode;
            seek_reg <= req_seek_position;
        end
        if (cmd.walk_init)
        begin
            rest_reg     <= flat_pos_reg;
            div_dim_reg  <= dims_used - 1'b1;
            emit_dim_reg <= '0;
        end
        else
        begin
            if (cmd.div_store)
            begin
                rest_reg    <= ext_zero ? '0 : div_quo;
                div_dim_reg <= div_dim_reg - 1'b1;
                coord_mem[div_dim_reg[CIDX_W-1:0]] <= ext_zero ? '0 : div_rem;
            end
            if (cmd.emit_coord)
            begin
                emit_dim_reg <= emit_dim_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ack || cmd.emit_exh || cmd.emit_coord)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ack || cmd.emit_exh)
        begin
            res_dim_reg   <= '0;
            res_coord_reg <= '0;
            res_pos_reg   <= flat_pos_reg;
            res_exh_reg   <= cmd.emit_exh;
            res_last_reg  <= 1'b1;
        end
        else if (cmd.emit_coord)
        begin
            res_dim_reg   <= emit_dim_reg;
            res_coord_reg <= coord_mem[emit_dim_reg[CIDX_W-1:0]];
            res_pos_reg   <= flat_pos_reg;
            res_exh_reg   <= 1'b0;
            res_last_reg  <= emit_last;
        end
    end

    assign status.op_seek      = (op_reg == OPC_SEEK);
    assign status.exhausted    = (flat_pos_reg >= total_reg);
    assign status.div_busy     = div_busy;
    assign status.div_done     = div_done;
    assign status.div_dim_zero = (div_dim_reg == '0);
    assign status.emit_last    = emit_last;
    assign status.out_free     = out_free;

    assign res_valid      = res_valid_reg;
    assign res_dimension  = res_dim_reg;
    assign res_coordinate = res_coord_reg;
    assign res_position   = res_pos_reg;
    assign res_exhausted  = res_exh_reg;
    assign res_last       = res_last_reg;

endmodule

@@ src/fitc_ctrl.sv @@
// fitc_ctrl: request sequencer; drives the datapath commands.
// Depends on fitc_pkg.
module fitc_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  fitc_pkg::fitc_status_t  status,
    output fitc_pkg::fitc_cmd_t     cmd
);
    import fitc_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_ACK       = 3'd2;
    localparam logic [2:0] S_EXH       = 3'd3;
    localparam logic [2:0] S_DIV_START = 3'd4;
    localparam logic [2:0] S_DIV_WAIT  = 3'd5;
    localparam logic [2:0] S_EMIT      = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.op_seek)
                begin
                    cmd.load_seek = 1'b1;
                    state_next    = S_ACK;
                end
                else if (status.exhausted)
                begin
                    state_next = S_EXH;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_DIV_START;
                end
            end
            S_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EXH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_exh = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = status.div_dim_zero ? S_EMIT : S_DIV_START;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_coord = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for flat_index_to_coordinates: directed and random requests,
// with a local predictor that checks every coordinate transfer.
// Depends on fitc_pkg, the fitc interfaces (src/fitc_ifs.sv) and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import fitc_pkg::*;

    // Timing. The slowest legal gap with no transfer is the long receiver
    // hold-off plus one six-dimension walk, so the quiet limit leaves a
    // wide margin.
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 240;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 4000;

    // One coordinate transfer, laid out like the result channel.
    typedef struct packed {
        logic [DIM_W-1:0] dimension;
        logic [EXT_W-1:0] coordinate;
        logic [POS_W-1:0] position;
        logic             exhausted;
        logic             last;
    } coord_result_t;

    logic clk;
    logic rst_n;

    fitc_req_if req_bus ();
    fitc_res_if res_bus ();
    fitc_cfg_if cfg_bus ();

    flat_index_to_coordinates DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // Shadow copy of the block: registers as written, plus the position counter.
    logic [DIM_W-1:0] shadow_dim_count;
    logic [POS_W-1:0] shadow_total;
    logic [EXT_W-1:0] shadow_extent [NUM_EXTENTS];
    logic [POS_W-1:0] shadow_position;

    coord_result_t expected_coords [$];
    int            mismatch_count;
    int            quiet_cycles;

    // Knobs shared between the stimulus thread and the result sink.
    bit source_gaps_on;
    bit sink_gaps_on;
    bit long_hold_pending;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: mixed-radix split of the flat position, innermost dimension
    // first, then emitted outermost first. Zero extents give coordinate 0 and
    // pass a zero quotient outward.
    // ------------------------------------------------------------------
    function automatic void predict_coordinates(input logic [OPC_W-1:0] op,
                                                input logic [POS_W-1:0] seek_pos);
        coord_result_t    r;
        logic [EXT_W-1:0] coord [NUM_EXTENTS];
        logic [POS_W-1:0] rest;
        int               n;
        r = '0;
        if (op == OPC_SEEK) begin
            shadow_position = seek_pos;
            r.position      = seek_pos;
            r.last          = 1'b1;
            expected_coords.push_back(r);
            return;
        end
        // counter at or past total: one exhausted transfer, counter holds
        if (shadow_position >= shadow_total) begin
            r.position  = shadow_position;
            r.exhausted = 1'b1;
            r.last      = 1'b1;
            expected_coords.push_back(r);
            return;
        end
        // dimension count is clamped into 1..MAX_DIMS
        n = shadow_dim_count;
        if (n < 1)
            n = 1;
        if (n > MAX_DIMS_DEF)
            n = MAX_DIMS_DEF;
        rest = shadow_position;
        for (int d = n - 1; d >= 0; d--) begin
            if (shadow_extent[d] == '0) begin
                coord[d] = '0;
                rest     = '0;
            end else begin
                coord[d] = EXT_W'(rest % {16'd0, shadow_extent[d]});
                rest     = rest / {16'd0, shadow_extent[d]};
            end
        end
        for (int d = 0; d < n; d++) begin
            r.dimension  = DIM_W'(d);
            r.coordinate = coord[d];
            r.position   = shadow_position;
            r.exhausted  = 1'b0;
            r.last       = (d == n - 1);
            expected_coords.push_back(r);
        end
        shadow_position = shadow_position + 1;
    endfunction

    function automatic void compare_field(input string field,
                                          input logic [POS_W-1:0] want,
                                          input logic [POS_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result sink: ready with random stall bursts, plus one long hold-off on
    // request. The hold-off length is counted here, not in the stimulus.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left == 0) begin
                if (long_hold_pending) begin
                    stall_left        = LONG_HOLD_CYCLES;
                    long_hold_pending = 1'b0;
                end else if (sink_gaps_on && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 15);
                end
            end
            if (stall_left != 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every result transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        coord_result_t want;
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (expected_coords.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %s %0d %0h %0h",
                         $time, "dim/coord/pos", res_bus.dimension,
                         res_bus.coordinate, res_bus.position);
            end else begin
                want = expected_coords.pop_front();
                compare_field("dimension",  POS_W'(want.dimension),  POS_W'(res_bus.dimension));
                compare_field("coordinate", POS_W'(want.coordinate),
                              POS_W'(res_bus.coordinate));
                compare_field("position",   want.position,           res_bus.position);
                compare_field("exhausted",  POS_W'(want.exhausted),  POS_W'(res_bus.exhausted));
                compare_field("last",       POS_W'(want.last),       POS_W'(res_bus.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on any channel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_coords.size());
                $display("FAIL flat_index_to_coordinates");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // One request transfer. Valid stays high after the transfer so that a
    // following call can offer the next item back to back; drain_results
    // drops it when the stream stops.
    task automatic send_request(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] seek_pos);
        if (source_gaps_on && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.opcode        <= op;
        req_bus.seek_position <= seek_pos;
        @(posedge clk);
        while (req_bus.ready !== 1'b1) @(posedge clk);
        predict_coordinates(op, seek_pos);
    endtask

    // Stop offering and wait until every expected result has been seen.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (expected_coords.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transfer; valid is left high, callers lower it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1) @(posedge clk);
        // only the low bits of each field are kept; unmapped indexes do nothing
        if (idx == CFG_DIM_COUNT)
            shadow_dim_count = value[DIM_W-1:0];
        else if (idx == CFG_TOTAL)
            shadow_total = value[POS_W-1:0];
        else if (idx >= CFG_EXTENT_FIRST && idx <= CFG_EXTENT_LAST)
            shadow_extent[EXT_IDX_W'(idx - CFG_EXTENT_FIRST)] = value[EXT_W-1:0];
    endtask

    task automatic write_single(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        write_register(idx, value);
        cfg_bus.valid <= 1'b0;
    endtask

    // Full register set in map order, optionally with a write to an unmapped index.
    task automatic set_shape(input logic [CFG_DATA_W-1:0] dims, input logic [CFG_DATA_W-1:0] total,
                             input logic [CFG_DATA_W-1:0] e0, input logic [CFG_DATA_W-1:0] e1,
                             input logic [CFG_DATA_W-1:0] e2, input logic [CFG_DATA_W-1:0] e3,
                             input logic [CFG_DATA_W-1:0] e4, input logic [CFG_DATA_W-1:0] e5,
                             input bit stray_write);
        write_register(CFG_DIM_COUNT, dims);
        write_register(CFG_TOTAL, total);
        write_register(CFG_EXTENT_FIRST, e0);
        write_register(CFG_IDX_W'(CFG_EXTENT_FIRST + 1), e1);
        write_register(CFG_IDX_W'(CFG_EXTENT_FIRST + 2), e2);
        write_register(CFG_IDX_W'(CFG_EXTENT_FIRST + 3), e3);
        write_register(CFG_IDX_W'(CFG_EXTENT_FIRST + 4), e4);
        write_register(CFG_EXTENT_LAST, e5);
        if (stray_write)
            write_register(CFG_IDX_W'($urandom_range(CFG_EXTENT_LAST + 1, 15)), $urandom);
        cfg_bus.valid <= 1'b0;
    endtask

    // Random geometry: mostly small extents so walks reach the end, with zero,
    // mid and full-range extents mixed in; total usually the extent product.
    task automatic program_random_shape();
        logic [DIM_W-1:0] dims;
        logic [EXT_W-1:0] ext [NUM_EXTENTS];
        logic [63:0]      product;
        logic [POS_W-1:0] total;
        logic [31:0]      noise;
        int               n;
        int               pick;
        pick = $urandom_range(0, 9);
        dims = (pick < 8) ? DIM_W'($urandom_range(1, 6)) : ((pick == 8) ? 3'd0 : 3'd7);
        for (int i = 0; i < NUM_EXTENTS; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                ext[i] = EXT_W'($urandom_range(1, 6));
            else if (pick == 6)
                ext[i] = '0;
            else if (pick == 7)
                ext[i] = EXT_W'($urandom_range(7, 300));
            else if (pick == 8)
                ext[i] = EXT_W'($urandom);
            else
                ext[i] = '1;
        end
        n = (dims == 0) ? 1 : ((dims > MAX_DIMS_DEF) ? MAX_DIMS_DEF : int'(dims));
        product = 64'd1;
        for (int i = 0; i < n; i++) begin
            if (ext[i] != '0)
                product = product * ext[i];
            if (product > 64'hFFFF_FFFF)
                product = 64'hFFFF_FFFF;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
            total = product[31:0];
        else if (pick == 6)
            total = product[31:0] - 1;
        else if (pick == 7)
            total = product[31:0] + $urandom_range(1, 5);
        else if (pick == 8)
            total = $urandom_range(0, 40);
        else
            total = $urandom;
        // upper data bits are junk the block must drop
        noise = $urandom;
        set_shape({noise[31:3], dims}, total,
                  {noise[15:0], ext[0]}, {noise[31:16], ext[1]}, {noise[23:8], ext[2]},
                  {~noise[15:0], ext[3]}, {~noise[31:16], ext[4]}, {noise[27:12], ext[5]},
                  $urandom_range(0, 3) == 0);
    endtask

    // Mostly well-formed walks (seek into range, then a run of next requests),
    // the rest lone requests, wild seeks and seeks past the end.
    task automatic run_random_items(input int item_budget);
        int               sent;
        int               pick;
        int               run_len;
        logic [POS_W-1:0] start_pos;
        sent = 0;
        while (sent < item_budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (shadow_total == '0)
                    start_pos = '0;
                else if (shadow_total > 8 && $urandom_range(0, 3) == 0)
                    start_pos = shadow_total - $urandom_range(1, 8);
                else
                    start_pos = $urandom_range(shadow_total - 1, 0);
                run_len = $urandom_range(1, 8);
                send_request(OPC_SEEK, start_pos);
                repeat (run_len) send_request(OPC_NEXT, $urandom);
                sent += 1 + run_len;
            end else if (pick < 70) begin
                send_request(OPC_NEXT, $urandom);
                sent += 1;
            end else if (pick < 80) begin
                send_request(OPC_SEEK, $urandom);
                sent += 1;
            end else if (pick < 90) begin
                send_request(OPC_SEEK, shadow_total + $urandom_range(0, 3));
                send_request(OPC_NEXT, $urandom);
                sent += 2;
            end else begin
                run_len = $urandom_range(1, 4);
                send_request(OPC_SEEK, '0);
                repeat (run_len) send_request(OPC_NEXT, $urandom);
                sent += 1 + run_len;
            end
            // now and then the sender waits for the block to empty
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state: one dimension of extent 1, total 1, counter 0.
    task automatic test_power_on_defaults();
        send_request(OPC_NEXT, '0);
        send_request(OPC_NEXT, '1);            // counter at total: exhausted
        send_request(OPC_SEEK, 32'hFFFF_FFFF);
        send_request(OPC_NEXT, '0);            // exhausted at the top position
        send_request(OPC_SEEK, '0);
        drain_results();
    endtask

    // 2 x 3 x 4 grid: start, last element, run past the end, middle.
    task automatic test_small_grid();
        set_shape(3, 24, 2, 3, 4, 1, 1, 1, 1'b0);
        send_request(OPC_NEXT, 32'hFFFF_FFFF); // seek field ignored on next
        send_request(OPC_SEEK, 23);
        send_request(OPC_NEXT, '0);
        send_request(OPC_NEXT, '0);
        send_request(OPC_SEEK, 13);
        send_request(OPC_NEXT, '0);
        drain_results();
    endtask

    // Six dimensions, total and extents at their top values, counter at the top of its range
    // (must stop, not wrap), then dimension counts outside 1..MAX_DIMS.
    task automatic test_register_extremes();
        set_shape(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(OPC_SEEK, 32'hFFFF_FFFE);
        send_request(OPC_NEXT, '0);
        send_request(OPC_NEXT, '0);
        drain_results();
        write_single(CFG_DIM_COUNT, 32'hFFFF_FFF8);   // count 0 acts as 1
        send_request(OPC_SEEK, 70000);
        send_request(OPC_NEXT, '0);
        drain_results();
        write_single(CFG_DIM_COUNT, 32'd7);           // count 7 acts as MAX_DIMS
        send_request(OPC_SEEK, 32'h1234_5678);
        send_request(OPC_NEXT, '0);
        drain_results();
    endtask

    // Zero extent inside the walk, an unmapped register write, zero total.
    task automatic test_zero_extent_and_totals();
        set_shape(4, 200, 3, 5, 0, 7, 9, 9, 1'b0);
        send_request(OPC_SEEK, 150);
        send_request(OPC_NEXT, '0);
        drain_results();
        write_single(4'd15, 32'hFFFF_FFFF);
        send_request(OPC_NEXT, '0);
        drain_results();
        write_single(CFG_TOTAL, '0);
        send_request(OPC_NEXT, '0);
        send_request(OPC_SEEK, '0);
        send_request(OPC_NEXT, '0);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the
    // block backs up and stalls its request side; then the sender waits it out.
    task automatic test_output_backpressure();
        source_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
        set_shape(6, 64, 2, 2, 2, 2, 2, 2, 1'b0);
        long_hold_pending = 1'b1;
        send_request(OPC_SEEK, 0);
        repeat (15) send_request(OPC_NEXT, $urandom);
        drain_results();
    endtask

    // Random geometries, with source and sink gaps switched per phase.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            source_gaps_on = (phase % 3 != 2);
            sink_gaps_on   = (phase % 4 != 1);
            program_random_shape();
            run_random_items(48);
        end
    endtask

    // Full-rate tail: no gaps on either side.
    task automatic test_streaming_tail();
        source_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
        program_random_shape();
        run_random_items(36);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        shadow_dim_count = DIM_W'(1);
        shadow_total     = POS_W'(1);
        shadow_position  = '0;
        for (int i = 0; i < NUM_EXTENTS; i++)
            shadow_extent[i] = EXT_W'(1);
        mismatch_count    = 0;
        quiet_cycles      = 0;
        source_gaps_on    = 1'b1;
        sink_gaps_on      = 1'b1;
        long_hold_pending = 1'b0;

        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.opcode        <= OPC_NEXT;
        req_bus.seek_position <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= CFG_DIM_COUNT;
        cfg_bus.data          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_small_grid();
        test_register_extremes();
        test_zero_extent_and_totals();
        test_output_backpressure();
        test_random_traffic();
        test_streaming_tail();

        // all results are in; give a late stray transfer time to show up
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS flat_index_to_coordinates");
        else
            $display("FAIL flat_index_to_coordinates");
        $finish;
    end

endmodule

@@ flat_index_to_coordinates.f @@
src/fitc_pkg.sv
src/fitc_ifs.sv
src/fitc_divider.sv
src/fitc_datapath.sv
src/fitc_ctrl.sv
src/flat_index_to_coordinates.sv
bench/testbench.sv
